[hdl/dqs_pkg.sv]
// Shared types and codes for the double-ended queue with search.
package dqs_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;
	localparam int POS_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

	// Per-cycle shift command broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_cmd_t;

endpackage

[hdl/dqs_req_if.sv]
// Request channel: operation and item, valid/ready handshake.
interface dqs_req_if import dqs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [DATA_W-1:0] item;

	modport source (output valid, output operation, output item, input ready);
	modport sink (input valid, input operation, input item, output ready);
endinterface

[hdl/dqs_rsp_if.sv]
// Response channel: status, value, position and occupancy, valid/ready handshake.
interface dqs_rsp_if import dqs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [DATA_W-1:0] value;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  occupancy;

	modport source (output valid, output status, output value, output position,
		output occupancy, input ready);
	modport sink (input valid, input status, input value, input position,
		input occupancy, output ready);
endinterface

[hdl/dqs_cell.sv]
// One queue cell: holds one item, shifts with its neighbors, compares for search.
module dqs_cell import dqs_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [DATA_W-1:0] item,
	input  logic [DATA_W-1:0] prev_data,
	input  logic              prev_valid,
	input  logic [DATA_W-1:0] next_data,
	input  logic              next_valid,
	input  logic              seen_in,
	output logic [DATA_W-1:0] data,
	output logic              valid,
	output logic              seen_out,
	output logic [DATA_W-1:0] last_data,
	output logic [POS_W-1:0]  hit_pos
);

	localparam logic [POS_W-1:0] POS = POS_W'(INDEX + 1);

	logic [DATA_W-1:0] data_q;
	logic              valid_q;
	logic              match;
	logic              is_last;
	logic              take_back;

	assign match     = valid_q && (data_q == item);
	assign is_last   = valid_q && !next_valid;
	assign take_back = cmd.push_back && !valid_q && prev_valid;

	assign data      = data_q;
	assign valid     = valid_q;
	assign seen_out  = seen_in || match;
	assign last_data = is_last ? data_q : '0;
	assign hit_pos   = (match && !seen_in) ? POS : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push_front) begin
			valid_q <= prev_valid;
		end else if (take_back) begin
			valid_q <= 1'b1;
		end else if (cmd.pop_front) begin
			valid_q <= next_valid;
		end else if (cmd.pop_back && is_last) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= prev_data;
		end else if (take_back) begin
			data_q <= item;
		end else if (cmd.pop_front) begin
			data_q <= next_data;
		end
	end

endmodule

[hdl/deque_with_search_core.sv]
// Double-ended queue with search: top level with the cell chain and response register.
//
// Usage:
//   req carries operation (push front, push back, pop front, pop back, search)
//   and item; rsp returns status, value, position and occupancy, one response
//   per request, in request order.
//   Items sit in a chain of DEPTH cells, the front in cell 0. Front pushes and
//   pops move every cell one place along the chain; a back push fills the first
//   free cell, a back pop clears the last held cell. A search compares all held
//   cells at once and a priority chain picks the first match.
//   Latency: the response is valid the cycle after the request transfer.
//   Throughput: one request per cycle while rsp is not held; the next request is taken while the
//   response register is emptied in the same cycle.
//   Stall: while rsp is held (valid and not ready), req.ready stays low and
//   the queue contents do not change.
//   Reset: arst_n clears the cell valid bits and the fill count, leaving the
//   queue empty; no clearing pass is needed.
module deque_with_search_core import dqs_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	dqs_req_if.sink req,
	dqs_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  fill_n;
	logic              rsp_valid_q;
	logic [ST_W-1:0]   rsp_status_q;
	logic [DATA_W-1:0] rsp_value_q;
	logic [POS_W-1:0]  rsp_position_q;
	logic [POS_W-1:0]  rsp_occupancy_q;

	logic              xfer;
	logic              full;
	logic              empty;
	cell_cmd_t         cmd;
	logic [ST_W-1:0]   status_n;
	logic [DATA_W-1:0] value_n;
	logic [POS_W-1:0]  position_n;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_last [DEPTH];
	logic [POS_W-1:0]  cell_pos  [DEPTH];
	logic [DEPTH-1:0]  cell_valid;
	logic [DEPTH:0]    seen;
	logic [DATA_W-1:0] back_data;
	logic [POS_W-1:0]  hit_pos;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign empty     = (fill_q == '0);
	assign seen[0]   = 1'b0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_W-1:0] prev_data;
			logic              prev_valid;
			logic [DATA_W-1:0] next_data;
			logic              next_valid;

			if (g == 0) begin : g_head
				assign prev_data  = req.item;
				assign prev_valid = 1'b1;
			end else begin : g_mid
				assign prev_data  = cell_data[g-1];
				assign prev_valid = cell_valid[g-1];
			end

			if (g == DEPTH - 1) begin : g_tail
				assign next_data  = '0;
				assign next_valid = 1'b0;
			end else begin : g_body
				assign next_data  = cell_data[g+1];
				assign next_valid = cell_valid[g+1];
			end

			dqs_cell #(.INDEX(g)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.item       (req.item),
				.prev_data  (prev_data),
				.prev_valid (prev_valid),
				.next_data  (next_data),
				.next_valid (next_valid),
				.seen_in    (seen[g]),
				.data       (cell_data[g]),
				.valid      (cell_valid[g]),
				.seen_out   (seen[g+1]),
				.last_data  (cell_last[g]),
				.hit_pos    (cell_pos[g])
			);
		end
	endgenerate

	// At most one cell is last and at most one cell is the first hit
	always_comb begin
		back_data = '0;
		hit_pos   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_data = back_data | cell_last[i];
			hit_pos   = hit_pos | cell_pos[i];
		end
	end

	always_comb begin
		cmd        = '0;
		status_n   = ST_OK;
		value_n    = '0;
		position_n = '0;
		fill_n     = fill_q;
		case (req.operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					cmd.push_front = xfer;
					fill_n         = fill_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					cmd.push_back = xfer;
					fill_n        = fill_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					cmd.pop_front = xfer;
					value_n       = cell_data[0];
					fill_n        = fill_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					cmd.pop_back = xfer;
					value_n      = back_data;
					fill_n       = fill_q - 1'b1;
				end
			end
			OP_SEARCH: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else if (seen[DEPTH]) begin
					position_n = hit_pos;
				end else begin
					status_n = ST_MISSING;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				fill_q <= fill_n;
			end
			if (xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_status_q    <= status_n;
			rsp_value_q     <= value_n;
			rsp_position_q  <= position_n;
			rsp_occupancy_q <= POS_W'(fill_n);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.value     = rsp_value_q;
	assign rsp.position  = rsp_position_q;
	assign rsp.occupancy = rsp_occupancy_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_fill_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(fill_q))
		else $error("fill count disagrees with cell valid bits");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + 1'b1) & cell_valid) == '0)
		else $error("held cells not packed toward the front");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && empty && (req.operation == OP_POP_FRONT || req.operation == OP_POP_BACK))
		|=> (rsp.valid && rsp.status == ST_EMPTY && rsp.value == '0))
		else $error("pop on empty queue not flagged");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> ($stable(fill_q) && $stable(cell_valid)))
		else $error("queue changed while response stalled");
`endif

endmodule
